// ===== sv/mck_pkg.sv =====
package mck_pkg;

    // Morse code of one character: symbols from bit 0 up, 1 = dash, 0 = dot
    typedef struct packed {
        logic       bad;      // no Morse code for this character
        logic [2:0] len;      // number of symbols, 0 to 6
        logic [5:0] pat;      // symbol pattern, first symbol in bit 0
        logic [1:0] tail_m1;  // trailing off units minus one
    } code_t;

    // controller to datapath
    typedef struct packed {
        logic load;  // take a new character
        logic step;  // produce the next unit into the output register
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic unit_last;  // the unit now due is the last of the run
    } dp_status_t;

    localparam logic [1:0] TailCode  = 2'd1;  // two off units after a code
    localparam logic [1:0] TailSpace = 2'd3;  // four off units for a space
    localparam logic [1:0] TailBad   = 2'd0;  // single flagged unit

    function automatic code_t mk(input logic [2:0] len, input logic [5:0] pat);
        code_t c;
        c.bad     = 1'b0;
        c.len     = len;
        c.pat     = pat;
        c.tail_m1 = TailCode;
        return c;
    endfunction

    function automatic code_t lookup(input logic [7:0] ch);
        code_t c;
        c = '{bad: 1'b1, len: 3'd0, pat: 6'd0, tail_m1: TailBad};
        unique case (ch)
            8'h20: c = '{bad: 1'b0, len: 3'd0, pat: 6'd0, tail_m1: TailSpace};
            8'h61: c = mk(3'd2, 6'b000010);  // a
            8'h62: c = mk(3'd4, 6'b000001);  // b
            8'h63: c = mk(3'd4, 6'b000101);  // c
            8'h64: c = mk(3'd3, 6'b000001);  // d
            8'h65: c = mk(3'd1, 6'b000000);  // e
            8'h66: c = mk(3'd4, 6'b000100);  // f
            8'h67: c = mk(3'd3, 6'b000011);  // g
            8'h68: c = mk(3'd4, 6'b000000);  // h
            8'h69: c = mk(3'd2, 6'b000000);  // i
            8'h6a: c = mk(3'd4, 6'b001110);  // j
            8'h6b: c = mk(3'd3, 6'b000101);  // k
            8'h6c: c = mk(3'd4, 6'b000010);  // l
            8'h6d: c = mk(3'd2, 6'b000011);  // m
            8'h6e: c = mk(3'd2, 6'b000001);  // n
            8'h6f: c = mk(3'd3, 6'b000111);  // o
            8'h70: c = mk(3'd4, 6'b000110);  // p
            8'h71: c = mk(3'd4, 6'b001011);  // q
            8'h72: c = mk(3'd3, 6'b000010);  // r
            8'h73: c = mk(3'd3, 6'b000000);  // s
            8'h74: c = mk(3'd1, 6'b000001);  // t
            8'h75: c = mk(3'd3, 6'b000100);  // u
            8'h76: c = mk(3'd4, 6'b001000);  // v
            8'h77: c = mk(3'd3, 6'b000110);  // w
            8'h78: c = mk(3'd4, 6'b001001);  // x
            8'h79: c = mk(3'd4, 6'b001101);  // y
            8'h7a: c = mk(3'd4, 6'b000011);  // z
            8'h2e: c = mk(3'd6, 6'b101010);  // full stop
            8'h2c: c = mk(3'd6, 6'b110011);  // comma
            8'h3a: c = mk(3'd6, 6'b000111);  // colon
            8'h3f: c = mk(3'd6, 6'b001100);  // question mark
            8'h27: c = mk(3'd6, 6'b011110);  // apostrophe
            8'h2d: c = mk(3'd6, 6'b100001);  // hyphen
            8'h2f: c = mk(3'd5, 6'b001001);  // slash
            8'h28: c = mk(3'd5, 6'b001101);  // open bracket
            8'h29: c = mk(3'd6, 6'b101101);  // close bracket
            8'h22: c = mk(3'd6, 6'b010010);  // double quote
            8'h3d: c = mk(3'd5, 6'b010001);  // equals
            8'h2b: c = mk(3'd5, 6'b001010);  // plus
            8'h40: c = mk(3'd6, 6'b010110);  // at sign
            8'h31: c = mk(3'd5, 6'b011110);
            8'h32: c = mk(3'd5, 6'b011100);
            8'h33: c = mk(3'd5, 6'b011000);
            8'h34: c = mk(3'd5, 6'b010000);
            8'h35: c = mk(3'd5, 6'b000000);
            8'h36: c = mk(3'd5, 6'b000001);
            8'h37: c = mk(3'd5, 6'b000011);
            8'h38: c = mk(3'd5, 6'b000111);
            8'h39: c = mk(3'd5, 6'b001111);
            8'h30: c = mk(3'd5, 6'b011111);
            default: ;
        endcase
        return c;
    endfunction

endpackage

// ===== sv/mck_dp.sv =====
module mck_dp (
    input  logic                   aclk,
    input  logic [7:0]             char_code,
    input  mck_pkg::ctrl_cmd_t     cmd,
    output mck_pkg::dp_status_t    status,
    output logic                   key_on,
    output logic                   last_unit,
    output logic                   bad_char
);

    mck_pkg::code_t code;
    logic [5:0] pat_reg;
    logic [2:0] len_reg;
    logic [2:0] sym_reg;
    logic [1:0] sub_reg;
    logic [1:0] tail_m1_reg;
    logic       bad_reg;
    logic       key_reg;
    logic       last_reg;
    logic       bad_out_reg;

    logic [7:0] pat_ext;
    logic       in_sym;
    logic       dash;
    logic       sym_end;
    logic       key;
    logic       unit_last;

    assign code    = mck_pkg::lookup(char_code);
    assign pat_ext = {2'b00, pat_reg};
    assign in_sym  = (sym_reg != len_reg);
    assign dash    = pat_ext[sym_reg];
    // dash: three on then one off; dot: one on then one off
    assign sym_end = dash ? (sub_reg == 2'd3) : (sub_reg == 2'd1);
    assign key     = in_sym && (dash ? (sub_reg != 2'd3) : (sub_reg == 2'd0));
    assign unit_last = !in_sym && (sub_reg == tail_m1_reg);

    assign status.unit_last = unit_last;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            pat_reg     <= code.pat;
            len_reg     <= code.len;
            tail_m1_reg <= code.tail_m1;
            bad_reg     <= code.bad;
            sym_reg     <= 3'd0;
            sub_reg     <= 2'd0;
        end else if (cmd.step) begin
            key_reg     <= key;
            last_reg    <= unit_last;
            bad_out_reg <= bad_reg;
            if (in_sym && sym_end) begin
                sym_reg <= sym_reg + 3'd1;
                sub_reg <= 2'd0;
            end else begin
                sub_reg <= sub_reg + 2'd1;
            end
        end
    end

    assign key_on    = key_reg;
    assign last_unit = last_reg;
    assign bad_char  = bad_out_reg;

endmodule

// ===== sv/mck_ctrl.sv =====
module mck_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  mck_pkg::dp_status_t    status,
    output mck_pkg::ctrl_cmd_t     cmd
);

    localparam logic StIdle = 1'b0;
    localparam logic StRun  = 1'b1;

    logic state_reg, state_next;
    logic m_tvalid_reg, m_tvalid_next;
    logic out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == StIdle);
    assign cmd.load = (state_reg == StIdle) && s_tvalid;
    assign cmd.step = (state_reg == StRun) && out_free;

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = cmd.step ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);
        unique case (state_reg)
            StIdle: begin
                if (s_tvalid) state_next = StRun;
            end
            StRun: begin
                if (cmd.step && status.unit_last) state_next = StIdle;
            end
            default: state_next = StIdle;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= StIdle;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

// ===== sv/morse_character_keyer.sv =====
// The first unit enters the output register on the first step after the character transfer.
// Each run is 1 to 22 units long; one unit per cycle while the receiver accepts, set by the
// single unit sequencer in the datapath, once the code of the character has been loaded.
// The next character is taken while the final unit of the previous run waits on the output.
// Reset: synchronous, active low; clears the controller state and the output valid only.
module morse_character_keyer (
    input  logic       aclk,
    input  logic       aresetn,
    // input channel
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_code
    // result channel, one transfer per key unit
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [0] key_on, [7:1] zero
    output logic       m_tlast,   // last_unit
    output logic       m_tuser    // [0] bad_char
);

    mck_pkg::ctrl_cmd_t  cmd;
    mck_pkg::dp_status_t status;
    logic                key_on;

    // Sequence control: hold the input while a run is in progress, advance the
    // datapath whenever the output register is empty or being drained.
    mck_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Code lookup, symbol and unit counters, and the output register.
    mck_dp u_dp (
        .aclk      (aclk),
        .char_code (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .key_on    (key_on),
        .last_unit (m_tlast),
        .bad_char  (m_tuser)
    );

    // Pad the key level out to a whole byte.
    assign m_tdata = {7'd0, key_on};

endmodule

// ===== sim/morse_character_keyer_tb.sv =====
module morse_character_keyer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 12;
    localparam int MAX_UNITS    = 22;   // longest run: comma, apostrophe, close bracket, zero
    localparam int N_RANDOM     = 200;
    localparam int LONG_HOLD    = 400;  // receiver hold-off, in cycles
    localparam int DRAIN_CYCLES = 30;

    localparam byte DASH_SYM  = "-";
    localparam byte SPACE_CHR = " ";

    // every character with a Morse keying, space included
    localparam string KEYED_SET = " abcdefghijklmnopqrstuvwxyz.,:?'-/()\"=+@0123456789";

    // one key unit as it should leave the block
    typedef struct packed {
        logic key_on;
        logic last_unit;
        logic bad_char;
    } key_unit_t;

    // directed stimulus: n_units = 0 means take the expected run from the predictor,
    // otherwise the run is n_units long with key levels in keys (unit 0 in bit 0)
    typedef struct packed {
        logic [7:0]  ch;
        logic [4:0]  n_units;
        logic [21:0] keys;
        logic        bad;
    } directed_row_t;

    localparam int N_DIRECTED = 25;
    localparam directed_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        {8'h00, 5'd1, 22'd0,        1'b1},  // NUL, all bits low
        {8'hFF, 5'd1, 22'd0,        1'b1},  // all bits high
        {8'h80, 5'd1, 22'd0,        1'b1},  // above the ASCII range
        {8'h41, 5'd1, 22'd0,        1'b1},  // upper case has no code
        {8'h7F, 5'd1, 22'd0,        1'b1},  // DEL
        {8'h20, 5'd4, 22'd0,        1'b0},  // space: four off units
        {"e",   5'd4, 22'b0001,     1'b0},  // single dot
        {"t",   5'd6, 22'b000111,   1'b0},  // single dash
        {",",   5'd0, 22'd0,        1'b0},  // longest run
        {".",   5'd0, 22'd0,        1'b0},
        {"0",   5'd0, 22'd0,        1'b0},  // five dashes
        {"5",   5'd0, 22'd0,        1'b0},  // five dots
        {"9",   5'd0, 22'd0,        1'b0},
        {"\"",  5'd0, 22'd0,        1'b0},
        {"@",   5'd0, 22'd0,        1'b0},
        {"'",   5'd0, 22'd0,        1'b0},
        {"a",   5'd0, 22'd0,        1'b0},
        {"z",   5'd0, 22'd0,        1'b0},
        {"(",   5'd0, 22'd0,        1'b0},
        {")",   5'd0, 22'd0,        1'b0},
        {"/",   5'd0, 22'd0,        1'b0},
        {"=",   5'd0, 22'd0,        1'b0},
        {"+",   5'd0, 22'd0,        1'b0},
        {"?",   5'd0, 22'd0,        1'b0},
        {":",   5'd0, 22'd0,        1'b0}
    };

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'd0;   // [7:0] char_code
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;           // [0] key_on, [7:1] zero
    logic       m_tlast;           // last_unit
    logic       m_tuser;           // [0] bad_char

    key_unit_t units_due[$];       // key units still owed by the block, oldest first

    int  n_errors      = 0;
    int  chars_sent    = 0;
    int  bad_sent      = 0;
    int  units_checked = 0;
    int  run_len       = 0;
    int  longest_run   = 0;
    bit  steady        = 1'b0;     // no idling on either side while set
    bit  hold_off_req  = 1'b0;     // ask the receiver for one long hold-off

    morse_character_keyer i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // End the run if the block hangs.
    initial begin
        #(10_000_000);
        $display("morse_character_keyer_tb: FAIL");
        $finish;
    end

    // Dot/dash string for a character; empty where there is no code.
    function automatic string morse_symbols(input logic [7:0] ch);
        case (ch)
            "a": return ".-";     "b": return "-...";   "c": return "-.-.";
            "d": return "-..";    "e": return ".";      "f": return "..-.";
            "g": return "--.";    "h": return "....";   "i": return "..";
            "j": return ".---";   "k": return "-.-";    "l": return ".-..";
            "m": return "--";     "n": return "-.";     "o": return "---";
            "p": return ".--.";   "q": return "--.-";   "r": return ".-.";
            "s": return "...";    "t": return "-";      "u": return "..-";
            "v": return "...-";   "w": return ".--";    "x": return "-..-";
            "y": return "-.--";   "z": return "--..";
            ".": return ".-.-.-"; ",": return "--..--"; ":": return "---...";
            "?": return "..--.."; "'": return ".----."; "-": return "-....-";
            "/": return "-..-.";  "(": return "-.--.";  ")": return "-.--.-";
            "\"": return ".-..-."; "=": return "-...-"; "+": return ".-.-.";
            "@": return ".--.-.";
            "1": return ".----";  "2": return "..---";  "3": return "...--";
            "4": return "....-";  "5": return ".....";  "6": return "-....";
            "7": return "--...";  "8": return "---..";  "9": return "----.";
            "0": return "-----";
            default: return "";
        endcase
    endfunction

    // Work out the key units one character causes and queue them.
    task automatic predict_keying(input logic [7:0] ch);
        key_unit_t run[$];
        string     sym;
        int        i;
        sym = morse_symbols(ch);
        if (ch == SPACE_CHR) begin
            repeat (4) run.push_back('{key_on: 1'b0, last_unit: 1'b0, bad_char: 1'b0});
        end else if (sym.len() == 0) begin
            run.push_back('{key_on: 1'b0, last_unit: 1'b1, bad_char: 1'b1});
            bad_sent++;
        end else begin
            for (i = 0; i < sym.len(); i++) begin
                repeat ((sym[i] == DASH_SYM) ? 3 : 1)
                    run.push_back('{key_on: 1'b1, last_unit: 1'b0, bad_char: 1'b0});
                run.push_back('{key_on: 1'b0, last_unit: 1'b0, bad_char: 1'b0});
            end
            repeat (2) run.push_back('{key_on: 1'b0, last_unit: 1'b0, bad_char: 1'b0});
        end
        while (run.size() > MAX_UNITS) void'(run.pop_back());
        run[run.size() - 1].last_unit = 1'b1;
        foreach (run[k]) units_due.push_back(run[k]);
    endtask

    // Mostly back to back, some short gaps, a few long ones.
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: mismatch on %s, unit %0d: got %0h, want %0h",
                 $time, what, units_checked, got, want);
        n_errors++;
    endtask

    // Offer one character and hold it until the block takes it. Returns at the
    // edge of the transfer, with s_tvalid still high.
    task automatic offer_char(input logic [7:0] ch);
        int gap;
        gap = idle_cycles();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        do @(posedge aclk); while (!s_tready);
        chars_sent++;
    endtask

    // Lower valid and wait until every owed unit has come out.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (units_due.size() != 0) @(posedge aclk);
    endtask

    // Receiver: random back-pressure, plus one long hold-off on request.
    initial begin
        int n;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else begin
                n = idle_cycles();
                if (n > 0) begin
                    m_tready <= 1'b0;
                    repeat (n) @(posedge aclk);
                end
            end
            m_tready <= 1'b1;
            repeat (steady ? 1 : $urandom_range(1, 8)) @(posedge aclk);
        end
    end

    // Checker: compare each result transfer with the oldest owed unit.
    always @(posedge aclk) begin
        key_unit_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (units_due.size() == 0) begin
                report_mismatch("unexpected result", {m_tlast, m_tuser, m_tdata}, 0);
            end else begin
                want = units_due.pop_front();
                if (m_tdata !== {7'd0, want.key_on})
                    report_mismatch("key_on (m_tdata)", m_tdata, want.key_on);
                if (m_tlast !== want.last_unit)
                    report_mismatch("last_unit (m_tlast)", m_tlast, want.last_unit);
                if (m_tuser !== want.bad_char)
                    report_mismatch("bad_char (m_tuser)", m_tuser, want.bad_char);
            end
            units_checked++;
            run_len++;
            if (m_tlast) begin
                if (run_len > longest_run) longest_run = run_len;
                run_len = 0;
            end
        end
    end

    // Stimulus: reset, directed table, then random characters.
    initial begin
        directed_row_t row;
        logic [7:0]    ch;
        int            i;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Walk the directed table; rows with a nonzero n_units carry their own expected run.
        for (i = 0; i < N_DIRECTED; i++) begin
            row = DIRECTED_ROWS[i];
            offer_char(row.ch);
            if (row.n_units == 0) begin
                predict_keying(row.ch);
            end else begin
                for (int u = 0; u < row.n_units; u++)
                    units_due.push_back('{key_on: row.keys[u],
                                          last_unit: (u == row.n_units - 1),
                                          bad_char: row.bad});
                if (row.bad) bad_sent++;
            end
        end

        // Mostly keyed characters, a quarter raw bytes of any value.
        for (i = 0; i < N_RANDOM; i++) begin
            if (i == 60)  steady = 1'b1;
            if (i == 100) steady = 1'b0;
            // hold the receiver off while characters keep coming
            if (i == 120) hold_off_req = 1'b1;
            // pause the sender until the block has emptied
            if (i == 160) wait_idle();
            if ($urandom_range(0, 3) == 0)
                ch = 8'($urandom_range(0, 255));
            else
                ch = KEYED_SET[$urandom_range(0, KEYED_SET.len() - 1)];
            offer_char(ch);
            predict_keying(ch);
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d characters (%0d without a code), checked %0d key units,",
                 chars_sent, bad_sent, units_checked);
        $display("longest run %0d units, with random gaps on both sides and a long hold-off.",
                 longest_run);
        if (n_errors == 0) begin
            $display("morse_character_keyer_tb: PASS");
        end else begin
            $display("morse_character_keyer_tb: FAIL");
        end
        $finish;
    end

endmodule
